/* rtl/rfg_pkg.sv */
// rfg_pkg: shared types and constants for the rgb fade/gamma controller
// no dependencies
package rfg_pkg;
  localparam int ChannelsDefault = 4;
  localparam logic [1:0] ActSet = 2'd0;
  localparam logic [1:0] ActDim = 2'd1;
  localparam logic [1:0] ActTick = 2'd2;
  localparam logic [9:0] TickReset = 10'd10;
  localparam logic [31:0] HalfLsb = 32'h0040_0000;

  typedef struct packed {
    logic [1:0]  action;
    logic [2:0]  channel;
    logic [7:0]  target_red;
    logic [7:0]  target_green;
    logic [7:0]  target_blue;
    logic [15:0] fade_ms;
    logic [7:0]  dim_amount;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  channel_index;
    logic [31:0] red_drive;
    logic [31:0] green_drive;
    logic [31:0] blue_drive;
    logic        last;
  } drv_t;
endpackage

/* rtl/rfg_if.sv */
// rfg_if: valid/ready channel carrying one payload beat
// no dependencies; the payload type is set by parameter T
interface rfg_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

/* rtl/rfg_front.sv */
// rfg_front: accepts command beats, drops unused ones, two-entry queue to the back end
// depends on rfg_pkg
module rfg_front #(
  parameter int CHANNELS = rfg_pkg::ChannelsDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  rfg_pkg::cmd_t in_data,
  output logic         q_valid,
  input  logic         q_ready,
  output rfg_pkg::cmd_t q_data
);
  rfg_pkg::cmd_t mem [2];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       keep, push, pop;

  assign keep = (in_data.action == rfg_pkg::ActTick) ||
                ((in_data.action == rfg_pkg::ActSet || in_data.action == rfg_pkg::ActDim) &&
                 ({29'd0, in_data.channel} < 32'(CHANNELS)));
  assign in_ready = (cnt != 2'd2);
  assign push = in_valid && in_ready && keep;
  assign q_valid = (cnt != 2'd0);
  assign pop = q_valid && q_ready;
  assign q_data = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= in_data;
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

/* rtl/rfg_back.sv */
// rfg_back: executes set, dim and tick commands; serial divider and channel walk
// depends on rfg_pkg
module rfg_back #(
  parameter int CHANNELS = rfg_pkg::ChannelsDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic [9:0]   tick_interval_ms,
  input  logic         q_valid,
  output logic         q_ready,
  input  rfg_pkg::cmd_t q_data,
  output logic         out_valid,
  input  logic         out_ready,
  output rfg_pkg::drv_t out_data
);
  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_SDIV, S_CDIV, S_STEP, S_SQR, S_EMIT
  } state_t;

  state_t state;
  logic [31:0] level [3*CHANNELS];
  logic [31:0] incr  [3*CHANNELS];
  logic [15:0] steps_left [CHANNELS];
  logic [3:0]  dim_shift [CHANNELS];

  rfg_pkg::cmd_t cmd;
  logic [CW-1:0] ch;
  logic [1:0]    col;
  logic [5:0]    bitn;
  logic [31:0]   quo, rem;
  logic [31:0]   tgt [3];
  logic [31:0]   drv [3];
  logic          neg;
  logic [15:0]   nsteps;

  logic [31:0] lv_sel, diff, mag;
  logic [32:0] rtry;
  logic [15:0] top;
  logic [31:0] sq;
  logic [31:0] div_den;
  logic [CW+1:0] idx;

  assign idx = {ch, 2'b00} - {2'b00, ch} + {{CW{1'b0}}, col};
  assign lv_sel = level[idx];
  assign diff = tgt[col] - lv_sel;
  assign mag = diff[31] ? (32'd0 - diff) : diff;
  assign div_den = (state == S_SDIV) ? {22'd0, tick_interval_ms} : {16'd0, nsteps};
  assign rtry = {rem, quo[31]} - {1'b0, div_den};
  assign top = lv_sel[30:15];
  assign sq = 32'(top) * 32'(top);
  assign q_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i < 3*CHANNELS; i++) begin
        level[i] <= '0;
        incr[i] <= '0;
      end
      for (int i = 0; i < CHANNELS; i++) begin
        steps_left[i] <= '0;
        dim_shift[i] <= '0;
      end
    end else begin
      if (out_valid && out_ready && (state != S_EMIT)) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cmd <= q_data;
            ch <= CW'(q_data.channel);
            col <= 2'd0;
            tgt[0] <= {1'b0, q_data.target_red, 23'd0} | rfg_pkg::HalfLsb;
            tgt[1] <= {1'b0, q_data.target_green, 23'd0} | rfg_pkg::HalfLsb;
            tgt[2] <= {1'b0, q_data.target_blue, 23'd0} | rfg_pkg::HalfLsb;
            case (q_data.action)
              rfg_pkg::ActDim: dim_shift[CW'(q_data.channel)] <= q_data.dim_amount[3:0];
              rfg_pkg::ActSet: begin
                quo <= {q_data.fade_ms, 16'd0};
                rem <= '0;
                bitn <= 6'd16;
                state <= (tick_interval_ms == 10'd0) ? S_STEP : S_SDIV;
                nsteps <= '0;
              end
              default: begin
                ch <= '0;
                state <= S_STEP;
              end
            endcase
          end
        end
        S_SDIV: begin
          rem <= rtry[32] ? {rem[30:0], quo[31]} : rtry[31:0];
          quo <= {quo[30:0], ~rtry[32]};
          bitn <= bitn - 6'd1;
          if (bitn == 6'd1) begin
            nsteps <= {quo[14:0], ~rtry[32]};
            state <= S_STEP;
          end
        end
        S_STEP: begin
          if (cmd.action == rfg_pkg::ActSet) begin
            if (nsteps < 16'd2) begin
              level[idx] <= tgt[col];
              steps_left[ch] <= '0;
              col <= col + 2'd1;
              if (col == 2'd2) state <= S_IDLE;
            end else begin
              neg <= diff[31];
              quo <= mag;
              rem <= '0;
              bitn <= 6'd32;
              state <= S_CDIV;
            end
          end else begin
            if (steps_left[ch] != 16'd0) begin
              for (int c = 0; c < 3; c++)
                level[idx - {{CW{1'b0}}, col} + (CW+2)'(c)] <=
                  level[idx - {{CW{1'b0}}, col} + (CW+2)'(c)] +
                  incr[idx - {{CW{1'b0}}, col} + (CW+2)'(c)];
              steps_left[ch] <= steps_left[ch] - 16'd1;
            end
            col <= 2'd0;
            state <= S_SQR;
          end
        end
        S_CDIV: begin
          rem <= rtry[32] ? {rem[30:0], quo[31]} : rtry[31:0];
          quo <= {quo[30:0], ~rtry[32]};
          bitn <= bitn - 6'd1;
          if (bitn == 6'd1) begin
            incr[idx] <= neg ? (32'd0 - {quo[30:0], ~rtry[32]}) : {quo[30:0], ~rtry[32]};
            col <= col + 2'd1;
            if (col == 2'd2) begin
              steps_left[ch] <= nsteps;
              state <= S_IDLE;
            end else state <= S_STEP;
          end
        end
        S_SQR: begin
          drv[col] <= sq >> dim_shift[ch];
          col <= col + 2'd1;
          if (col == 2'd2) state <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_data.channel_index <= 2'(ch);
            out_data.red_drive <= drv[0];
            out_data.green_drive <= drv[1];
            out_data.blue_drive <= drv[2];
            out_data.last <= ({{(32-CW){1'b0}}, ch} == 32'(CHANNELS - 1));
            if ({{(32-CW){1'b0}}, ch} == 32'(CHANNELS - 1)) state <= S_IDLE;
            else begin
              ch <= ch + CW'(1);
              state <= S_STEP;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

/* rtl/rgb_fade_gamma_controller.sv */
// rgb_fade_gamma_controller: per-channel rgb fader with gamma 2.0 drive output
// depends on rfg_pkg, rfg_if, rfg_front, rfg_back
//
// usage:
//   cmd (sink) takes command beats: set colour with fade, set dim, refresh tick
//   drv (source) gives one beat per channel on each tick, last on the final one
//   cfg_we/cfg_wdata write the tick interval in ms (reset value 10)
// operation:
//   a front queue of two entries takes beats while the back end is busy
//   set: a serial divide of the fade time by the tick interval, then per
//   colour an increment divide (one quotient bit a cycle); a zero interval
//   or a fade under two steps loads the targets directly; dim: stored in idle
//   tick: per channel a step, a square per colour, then the output beat
// reset clears all levels, increments, step counters and dim shifts
// when the receiver stalls the back end holds its output register and waits;
// the queue fills and then cmd.ready drops
module rgb_fade_gamma_controller #(
  parameter int CHANNELS = rfg_pkg::ChannelsDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [9:0] cfg_wdata,
  rfg_if.sink        cmd,
  rfg_if.source      drv
);
  logic [9:0] tick_interval_ms;
  logic q_valid, q_ready;
  rfg_pkg::cmd_t q_data;

  always_ff @(posedge clk) begin
    if (rst) tick_interval_ms <= rfg_pkg::TickReset;
    else if (cfg_we) tick_interval_ms <= cfg_wdata;
  end

  rfg_front #(.CHANNELS(CHANNELS)) u_front (
    .clk, .rst,
    .in_valid(cmd.valid), .in_ready(cmd.ready), .in_data(cmd.data),
    .q_valid, .q_ready, .q_data
  );

  rfg_back #(.CHANNELS(CHANNELS)) u_back (
    .clk, .rst, .tick_interval_ms,
    .q_valid, .q_ready, .q_data,
    .out_valid(drv.valid), .out_ready(drv.ready), .out_data(drv.data)
  );

  a_last_ok: assert property (@(posedge clk) disable iff (rst)
    drv.valid && drv.data.last |-> 32'(drv.data.channel_index) == 32'((CHANNELS - 1) % 4))
    else $error("last flag on wrong channel");
  a_cfg: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> tick_interval_ms == $past(cfg_wdata))
    else $error("tick interval not written");
endmodule
